// ===== src/aspect_locked_resize_defines.svh =====
`ifndef ASPECT_LOCKED_RESIZE_DEFINES_SVH
`define ASPECT_LOCKED_RESIZE_DEFINES_SVH

// property checked on every clock edge out of reset
`define ALR_CHECK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("aspect_locked_resize check failed");

// condition in one cycle implies another in the next cycle
`define ALR_NEXT(lbl, cond, nxt) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (nxt)) \
    else $error("aspect_locked_resize sequence check failed");

`endif

// ===== src/alr_pkg.sv =====
package alr_pkg;

  localparam int CoordBits  = 16;
  localparam int ThBits     = 12;
  localparam int RatioBits  = 16;
  localparam int DenBits    = RatioBits + 1;
  localparam int ProdBits   = CoordBits + RatioBits;
  localparam int NumBits    = ProdBits + 2;
  localparam int ExtBits    = NumBits + 3;
  localparam int OutBits    = 32;
  localparam int CfgIdxBits = 2;
  localparam int CfgBits    = 16;
  localparam int EdgeBits   = 4;

  typedef enum logic [EdgeBits-1:0] {
    EDGE_NONE = 4'd0,
    EDGE_L    = 4'd1,
    EDGE_R    = 4'd2,
    EDGE_T    = 4'd3,
    EDGE_B    = 4'd4,
    EDGE_TL   = 4'd5,
    EDGE_TR   = 4'd6,
    EDGE_BL   = 4'd7,
    EDGE_BR   = 4'd8
  } alr_edge_e;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_TITLE_H   = 2'd0,
    REG_CONTENT_W = 2'd1,
    REG_CONTENT_H = 2'd2
  } alr_reg_e;

  typedef struct packed {
    logic signed [CoordBits-1:0] l;
    logic signed [CoordBits-1:0] t;
    logic signed [CoordBits-1:0] r;
    logic signed [CoordBits-1:0] b;
    logic [EdgeBits-1:0]         edg;
    logic [CoordBits-1:0]        w;
    logic [CoordBits-1:0]        h;
    logic [ThBits-1:0]           th;
  } alr_item_t;

  typedef struct packed {
    logic [NumBits-1:0] num;
    logic [NumBits-1:0] quo;
    logic [DenBits-1:0] den;
    logic [DenBits-1:0] rem;
  } alr_div_t;

  typedef struct packed {
    logic      vld;
    alr_item_t item;
    alr_div_t  dh;
    alr_div_t  dw;
  } alr_lane_t;

  function automatic alr_div_t alr_div_step(alr_div_t d);
    alr_div_t         o;
    logic [DenBits:0] trial;
    logic [DenBits:0] diff;
    logic             ge;
    trial = {d.rem, d.num[NumBits-1]};
    diff  = trial - {1'b0, d.den};
    ge    = (trial >= {1'b0, d.den});
    o.den = d.den;
    o.num = {d.num[NumBits-2:0], 1'b0};
    o.quo = {d.quo[NumBits-2:0], ge};
    o.rem = ge ? diff[DenBits-1:0] : trial[DenBits-1:0];
    return o;
  endfunction

  function automatic logic signed [ExtBits-1:0] alr_half(logic signed [ExtBits-1:0] x);
    logic signed [ExtBits-1:0] s;
    s = x + $signed({{(ExtBits-1){1'b0}}, x[ExtBits-1]});
    return s >>> 1;
  endfunction

  function automatic logic signed [OutBits-1:0] alr_sat(logic signed [ExtBits-1:0] x);
    logic signed [ExtBits-1:0] hi;
    logic signed [ExtBits-1:0] lo;
    hi = $signed({{(ExtBits-OutBits+1){1'b0}}, {(OutBits-1){1'b1}}});
    lo = $signed({{(ExtBits-OutBits+1){1'b1}}, {(OutBits-1){1'b0}}});
    if (x > hi) begin
      return hi[OutBits-1:0];
    end else if (x < lo) begin
      return lo[OutBits-1:0];
    end
    return x[OutBits-1:0];
  endfunction

endpackage

// ===== src/alr_div_cell.sv =====
module alr_div_cell
  import alr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  alr_lane_t lane_i,
  output alr_lane_t lane_o
);

  logic      vld_q;
  alr_lane_t data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= lane_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q.vld  <= lane_i.vld;
      data_q.item <= lane_i.item;
      data_q.dh   <= alr_div_step(lane_i.dh);
      data_q.dw   <= alr_div_step(lane_i.dw);
    end
  end

  always_comb begin
    lane_o     = data_q;
    lane_o.vld = vld_q;
  end

endmodule

// ===== src/aspect_locked_resize.sv =====
// channel | direction | handshake                | payload
// config  | in        | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
// rect    | in        | in_valid_i / in_stall_o   | rect_*_i, edge_req_i
// result  | out       | out_valid_o / out_stall_i | new_*_o
//
// one rectangle per cycle while the result is not stalled
// the two divider chains compute one quotient bit per cell
// reset clears all valid bits and sets the ratio to 1:1, title height 0
// a stalled result freezes the whole pipe and raises in_stall_o
`include "aspect_locked_resize_defines.svh"

module aspect_locked_resize
  import alr_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [CfgIdxBits-1:0]       cfg_index_i,
  input  logic [CfgBits-1:0]          cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [CoordBits-1:0] rect_left_i,
  input  logic signed [CoordBits-1:0] rect_top_i,
  input  logic signed [CoordBits-1:0] rect_right_i,
  input  logic signed [CoordBits-1:0] rect_bottom_i,
  input  logic [EdgeBits-1:0]         edge_req_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [OutBits-1:0]   new_left_o,
  output logic signed [OutBits-1:0]   new_top_o,
  output logic signed [OutBits-1:0]   new_right_o,
  output logic signed [OutBits-1:0]   new_bottom_o
);

  typedef struct packed {
    alr_item_t             item;
    logic [CoordBits-1:0]  hm;
    logic [RatioBits-1:0]  cw;
    logic [RatioBits-1:0]  ch;
  } s1_t;

  typedef struct packed {
    alr_item_t             item;
    logic [ProdBits-1:0]   ph;
    logic [ProdBits-1:0]   pw;
    logic [RatioBits-1:0]  cw;
    logic [RatioBits-1:0]  ch;
  } s2_t;

  typedef struct packed {
    alr_item_t                 item;
    logic signed [ExtBits-1:0] hfw;
    logic signed [ExtBits-1:0] wfh;
  } s3_t;

  typedef struct packed {
    alr_item_t                 item;
    logic signed [ExtBits-1:0] hfw;
    logic signed [ExtBits-1:0] wfh;
    logic                      set_h;
    logic                      set_w;
  } s4_t;

  logic [ThBits-1:0]    th_q;
  logic [RatioBits-1:0] cw_q, ch_q;

  logic en;
  logic s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  s4_t  s4_d, s4_q;
  logic signed [OutBits-1:0] l_d, t_d, r_d, b_d;
  logic signed [OutBits-1:0] l_q, t_q, r_q, b_q;

  alr_lane_t lane [NumBits+1];

  assign cfg_ready_o = 1'b1;
  assign en          = !(s5_vld_q && out_stall_i);
  assign in_stall_o  = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      th_q <= '0;
      cw_q <= RatioBits'(1);
      ch_q <= RatioBits'(1);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_TITLE_H:   th_q <= cfg_data_i[ThBits-1:0];
        REG_CONTENT_W: cw_q <= cfg_data_i[RatioBits-1:0];
        REG_CONTENT_H: ch_q <= cfg_data_i[RatioBits-1:0];
        default: ;
      endcase
    end
  end

  // width, height and height below the title bar, clamped to 1
  always_comb begin
    logic signed [CoordBits:0] dw;
    logic signed [CoordBits:0] dh;
    logic signed [CoordBits:0] dm;
    dw = {rect_right_i[CoordBits-1], rect_right_i} - {rect_left_i[CoordBits-1], rect_left_i};
    dh = {rect_bottom_i[CoordBits-1], rect_bottom_i} - {rect_top_i[CoordBits-1], rect_top_i};
    s1_d.item.l   = rect_left_i;
    s1_d.item.t   = rect_top_i;
    s1_d.item.r   = rect_right_i;
    s1_d.item.b   = rect_bottom_i;
    s1_d.item.edg = edge_req_i;
    s1_d.item.th  = th_q;
    s1_d.item.w   = (dw > 0) ? dw[CoordBits-1:0] : CoordBits'(1);
    s1_d.item.h   = (dh > 0) ? dh[CoordBits-1:0] : CoordBits'(1);
    dm = $signed({1'b0, s1_d.item.h}) - $signed({{(CoordBits+1-ThBits){1'b0}}, th_q});
    s1_d.hm = (dm > 0) ? dm[CoordBits-1:0] : CoordBits'(1);
    s1_d.cw = (cw_q == '0) ? RatioBits'(1) : cw_q;
    s1_d.ch = (ch_q == '0) ? RatioBits'(1) : ch_q;
  end

  always_comb begin
    s2_d.item = s1_q.item;
    s2_d.ph   = s1_q.item.w * s1_q.ch;
    s2_d.pw   = s1_q.hm * s1_q.cw;
    s2_d.cw   = s1_q.cw;
    s2_d.ch   = s1_q.ch;
  end

  // numerators 2ab + c over denominators 2c
  always_comb begin
    lane[0].vld     = s2_vld_q;
    lane[0].item    = s2_q.item;
    lane[0].dh.num  = {1'b0, s2_q.ph, 1'b0} + NumBits'(s2_q.cw);
    lane[0].dh.den  = {s2_q.cw, 1'b0};
    lane[0].dh.quo  = '0;
    lane[0].dh.rem  = '0;
    lane[0].dw.num  = {1'b0, s2_q.pw, 1'b0} + NumBits'(s2_q.ch);
    lane[0].dw.den  = {s2_q.ch, 1'b0};
    lane[0].dw.quo  = '0;
    lane[0].dw.rem  = '0;
  end

  for (genvar k = 0; k < NumBits; k++) begin : g_cell
    alr_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .lane_i (lane[k]),
      .lane_o (lane[k+1])
    );
  end

  always_comb begin
    logic [NumBits-1:0] qh;
    logic [NumBits-1:0] qw;
    qh = (lane[NumBits].dh.quo == '0) ? NumBits'(1) : lane[NumBits].dh.quo;
    qw = (lane[NumBits].dw.quo == '0) ? NumBits'(1) : lane[NumBits].dw.quo;
    s3_d.item = lane[NumBits].item;
    s3_d.hfw  = $signed({3'b000, qh}) + $signed(ExtBits'(lane[NumBits].item.th));
    s3_d.wfh  = $signed({3'b000, qw});
  end

  // corner picks the smaller change, a tie goes to the height
  always_comb begin
    logic signed [ExtBits-1:0] eh;
    logic signed [ExtBits-1:0] ew;
    eh = s3_q.hfw - $signed(ExtBits'(s3_q.item.h));
    ew = s3_q.wfh - $signed(ExtBits'(s3_q.item.w));
    if (eh < 0) eh = -eh;
    if (ew < 0) ew = -ew;
    s4_d.item  = s3_q.item;
    s4_d.hfw   = s3_q.hfw;
    s4_d.wfh   = s3_q.wfh;
    s4_d.set_h = 1'b0;
    s4_d.set_w = 1'b0;
    case (s3_q.item.edg)
      EDGE_L, EDGE_R: s4_d.set_h = 1'b1;
      EDGE_T, EDGE_B: s4_d.set_w = 1'b1;
      EDGE_TL, EDGE_TR, EDGE_BL, EDGE_BR: begin
        s4_d.set_h = (eh <= ew);
        s4_d.set_w = !(eh <= ew);
      end
      default: ;
    endcase
  end

  always_comb begin
    logic signed [ExtBits-1:0] l, t, r, b;
    l = ExtBits'(s4_q.item.l);
    t = ExtBits'(s4_q.item.t);
    r = ExtBits'(s4_q.item.r);
    b = ExtBits'(s4_q.item.b);
    if (s4_q.set_h) begin
      case (s4_q.item.edg)
        EDGE_TL, EDGE_TR: t = b - s4_q.hfw;
        EDGE_BL, EDGE_BR: b = t + s4_q.hfw;
        default: begin
          t = alr_half(t + b - s4_q.hfw);
          b = t + s4_q.hfw;
        end
      endcase
    end
    if (s4_q.set_w) begin
      case (s4_q.item.edg)
        EDGE_TL, EDGE_BL: l = r - s4_q.wfh;
        EDGE_TR, EDGE_BR: r = l + s4_q.wfh;
        default: begin
          l = alr_half(l + r - s4_q.wfh);
          r = l + s4_q.wfh;
        end
      endcase
    end
    l_d = alr_sat(l);
    t_d = alr_sat(t);
    r_d = alr_sat(r);
    b_d = alr_sat(b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      s5_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= lane[NumBits].vld;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
      l_q  <= l_d;
      t_q  <= t_d;
      r_q  <= r_d;
      b_q  <= b_d;
    end
  end

  assign out_valid_o  = s5_vld_q;
  assign new_left_o   = l_q;
  assign new_top_o    = t_q;
  assign new_right_o  = r_q;
  assign new_bottom_o = b_q;

  `ALR_CHECK(a_stall_backs_up, !(out_valid_o && out_stall_i) || in_stall_o)
  `ALR_CHECK(a_ratio_nonzero, !s1_vld_q || ((s1_q.cw != '0) && (s1_q.ch != '0)))
  `ALR_NEXT(a_chain_to_s3, lane[NumBits].vld && !in_stall_o, s3_vld_q)
  `ALR_NEXT(a_result_held, out_valid_o && out_stall_i, out_valid_o && $stable(new_top_o))

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import alr_pkg::*;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        cfg_valid_i;
  logic                        cfg_ready_o;
  logic [CfgIdxBits-1:0]       cfg_index_i;
  logic [CfgBits-1:0]          cfg_data_i;
  logic                        in_valid_i;
  logic                        in_stall_o;
  logic signed [CoordBits-1:0] rect_left_i;
  logic signed [CoordBits-1:0] rect_top_i;
  logic signed [CoordBits-1:0] rect_right_i;
  logic signed [CoordBits-1:0] rect_bottom_i;
  logic [EdgeBits-1:0]         edge_req_i;
  logic                        out_valid_o;
  logic                        out_stall_i;
  logic signed [OutBits-1:0]   new_left_o;
  logic signed [OutBits-1:0]   new_top_o;
  logic signed [OutBits-1:0]   new_right_o;
  logic signed [OutBits-1:0]   new_bottom_o;

  typedef struct {
    logic signed [OutBits-1:0] l;
    logic signed [OutBits-1:0] t;
    logic signed [OutBits-1:0] r;
    logic signed [OutBits-1:0] b;
  } rect_t;

  typedef struct {
    logic signed [CoordBits-1:0] l;
    logic signed [CoordBits-1:0] t;
    logic signed [CoordBits-1:0] r;
    logic signed [CoordBits-1:0] b;
    logic [EdgeBits-1:0]         edg;
    bit                          typed;
    rect_t                       res;
  } stim_row_t;

  localparam int PipeLatency = NumBits + 5;

  rect_t       resized_q[$];
  int          fail_cnt;
  int          hold_cycles;
  bit          drain_hold;
  logic [11:0] title_h;
  logic [15:0] ratio_w;
  logic [15:0] ratio_h;
  stim_row_t   rows[$];

  aspect_locked_resize u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint round_ratio(longint a, longint b, longint c);
    return (2 * a * b + c) / (2 * c);
  endfunction

  function automatic logic signed [OutBits-1:0] sat32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[OutBits-1:0];
  endfunction

  function automatic rect_t resize_rect(logic signed [CoordBits-1:0] il,
                                        logic signed [CoordBits-1:0] it,
                                        logic signed [CoordBits-1:0] ir,
                                        logic signed [CoordBits-1:0] ib,
                                        logic [EdgeBits-1:0] edg);
    longint l, t, r, b, th, cw, ch, w, h, hfw, wfh, hs, dh, dw;
    bit     set_h, set_w;
    rect_t  o;
    l = il; t = it; r = ir; b = ib;
    th = title_h;
    cw = (ratio_w == 0) ? 1 : ratio_w;
    ch = (ratio_h == 0) ? 1 : ratio_h;
    w = (r - l > 1) ? r - l : 1;
    h = (b - t > 1) ? b - t : 1;
    hfw = round_ratio(w, ch, cw);
    hfw = th + ((hfw > 1) ? hfw : 1);
    hs = (h - th > 1) ? h - th : 1;
    wfh = round_ratio(hs, cw, ch);
    if (wfh < 1) wfh = 1;
    set_h = 0;
    set_w = 0;
    case (edg)
      EDGE_L, EDGE_R: set_h = 1;
      EDGE_T, EDGE_B: set_w = 1;
      EDGE_TL, EDGE_TR, EDGE_BL, EDGE_BR: begin
        dh = hfw - h; if (dh < 0) dh = -dh;
        dw = wfh - w; if (dw < 0) dw = -dw;
        if (dh <= dw) set_h = 1;
        else set_w = 1;
      end
      default: ;
    endcase
    if (set_h) begin
      if (edg == EDGE_TL || edg == EDGE_TR) t = b - hfw;
      else if (edg == EDGE_BL || edg == EDGE_BR) b = t + hfw;
      else begin
        t = (t + b - hfw) / 2;
        b = t + hfw;
      end
    end
    if (set_w) begin
      if (edg == EDGE_TL || edg == EDGE_BL) l = r - wfh;
      else if (edg == EDGE_TR || edg == EDGE_BR) r = l + wfh;
      else begin
        l = (l + r - wfh) / 2;
        r = l + wfh;
      end
    end
    o.l = sat32(l); o.t = sat32(t); o.r = sat32(r); o.b = sat32(b);
    return o;
  endfunction

  task automatic write_reg(alr_reg_e idx, logic [CfgBits-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_TITLE_H:   title_h = val[11:0];
      REG_CONTENT_W: ratio_w = val;
      REG_CONTENT_H: ratio_h = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (resized_q.size() != 0) @(posedge clk_i);
    repeat (PipeLatency + 5) @(posedge clk_i);
  endtask

  task automatic send_rect(logic signed [CoordBits-1:0] l, logic signed [CoordBits-1:0] t,
                           logic signed [CoordBits-1:0] r, logic signed [CoordBits-1:0] b,
                           logic [EdgeBits-1:0] edg, bit typed, rect_t res);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    rect_left_i   <= l;
    rect_top_i    <= t;
    rect_right_i  <= r;
    rect_bottom_i <= b;
    edge_req_i    <= edg;
    do @(posedge clk_i); while (in_stall_o);
    resized_q.push_back(typed ? res : resize_rect(l, t, r, b, edg));
  endtask

  task automatic idle_input();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  function automatic logic signed [CoordBits-1:0] rnd_coord();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return CoordBits'($urandom_range(0, 400) - 200);
      default: return CoordBits'($urandom());
    endcase
  endfunction

  task automatic random_phase(int n);
    logic signed [CoordBits-1:0] l, t, r, b;
    rect_t                       dummy;
    for (int i = 0; i < n; i++) begin
      l = rnd_coord();
      t = rnd_coord();
      if ($urandom_range(0, 3) != 0) begin
        r = CoordBits'(l + $urandom_range(1, 2000));
        b = CoordBits'(t + $urandom_range(1, 2000));
      end else begin
        r = rnd_coord();
        b = rnd_coord();
      end
      send_rect(l, t, r, b, EdgeBits'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
                : $urandom_range(0, 8)), 1'b0, dummy);
    end
    idle_input();
  endtask

  function automatic stim_row_t row(int l, int t, int r, int b, alr_edge_e e);
    stim_row_t s;
    s.l = CoordBits'(l); s.t = CoordBits'(t); s.r = CoordBits'(r); s.b = CoordBits'(b);
    s.edg = e; s.typed = 0;
    return s;
  endfunction

  function automatic stim_row_t known(int l, int t, int r, int b, logic [3:0] e,
                                      int ol, int ot, int orr, int ob);
    stim_row_t s;
    s = row(l, t, r, b, EDGE_NONE);
    s.edg = e; s.typed = 1;
    s.res.l = ol; s.res.t = ot; s.res.r = orr; s.res.b = ob;
    return s;
  endfunction

  // sink: random stalls, one long hold-off on request
  initial begin
    int s;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_cycles) @(negedge clk_i);
        hold_cycles = 0;
      end
      s = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
      if ($urandom_range(0, 3) == 0) s = 0;
      out_stall_i <= (s != 0);
      if (s != 0) begin
        repeat (s - 1) @(negedge clk_i);
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  always @(posedge clk_i) begin
    rect_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (resized_q.size() == 0) begin
        $display("%0t: unexpected beat l=%0d t=%0d r=%0d b=%0d", $time,
                 new_left_o, new_top_o, new_right_o, new_bottom_o);
        fail_cnt++;
      end else begin
        exp_r = resized_q.pop_front();
        if (exp_r.l !== new_left_o || exp_r.t !== new_top_o ||
            exp_r.r !== new_right_o || exp_r.b !== new_bottom_o) begin
          $display("%0t: mismatch expected l=%0d t=%0d r=%0d b=%0d actual l=%0d t=%0d r=%0d b=%0d",
                   $time, exp_r.l, exp_r.t, exp_r.r, exp_r.b,
                   new_left_o, new_top_o, new_right_o, new_bottom_o);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    int cnt;
    fail_cnt      = 0;
    hold_cycles   = 0;
    title_h       = 0;
    ratio_w       = 1;
    ratio_h       = 1;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = REG_TITLE_H;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    rect_left_i   = '0;
    rect_top_i    = '0;
    rect_right_i  = '0;
    rect_bottom_i = '0;
    edge_req_i    = EDGE_NONE;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // 1:1 after reset
    rows.push_back(known(0, 0, 10, 20, EDGE_NONE, 0, 0, 10, 20));
    rows.push_back(known(0, 0, 10, 20, EDGE_L, 0, 5, 10, 15));
    rows.push_back(known(0, 0, 10, 20, EDGE_T, -5, 0, 15, 20));
    rows.push_back(known(0, 0, 10, 20, 4'd12, 0, 0, 10, 20));
    rows.push_back(known(5, 5, 5, 5, EDGE_BR, 5, 5, 5, 6));
    rows.push_back(known(-32768, -32768, 32767, 32767, EDGE_NONE,
                         -32768, -32768, 32767, 32767));
    rows.push_back(known(32767, 32767, -32768, -32768, EDGE_R, 32767, -1, -32768, 0));
    rows.push_back(row(32767, 32767, -32768, -32768, EDGE_TL));
    rows.push_back(row(-32768, -32768, 32767, 32767, EDGE_B));
    rows.push_back(row(0, 0, 30, 10, EDGE_TR));
    rows.push_back(row(0, 0, 30, 10, EDGE_BL));
    rows.push_back(row(0, 0, 10, 30, EDGE_TL));
    rows.push_back(row(-7, -3, 4, 2, EDGE_T));
    rows.push_back(row(-7, -3, 4, 2, EDGE_R));
    rows.push_back(row(-1, -1, 0, 0, EDGE_BR));
    foreach (rows[i])
      send_rect(rows[i].l, rows[i].t, rows[i].r, rows[i].b, rows[i].edg,
                rows[i].typed, rows[i].res);
    idle_input();
    wait_drained();

    // extreme ratios and title heights, zeros taken as one
    write_reg(REG_TITLE_H, 16'd4095);
    write_reg(REG_CONTENT_W, 16'd65535);
    write_reg(REG_CONTENT_H, 16'd1);
    random_phase(300);
    wait_drained();

    write_reg(REG_CONTENT_W, 16'd0);
    write_reg(REG_CONTENT_H, 16'd65535);
    write_reg(REG_TITLE_H, 16'hffff);
    random_phase(300);
    wait_drained();

    write_reg(REG_TITLE_H, 16'd0);
    write_reg(REG_CONTENT_W, 16'd16);
    write_reg(REG_CONTENT_H, 16'd0);
    // long sink hold-off while the source keeps offering
    hold_cycles = 200;
    random_phase(300);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      write_reg(REG_TITLE_H, CfgBits'($urandom_range(0, 4095)));
      write_reg(REG_CONTENT_W, CfgBits'($urandom()));
      write_reg(REG_CONTENT_H, CfgBits'($urandom()));
      random_phase(260);
      wait_drained();
    end

    cnt = 0;
    while (resized_q.size() != 0 && cnt < 100000) begin
      @(posedge clk_i);
      cnt++;
    end
    repeat (PipeLatency + 10) @(posedge clk_i);
    if (resized_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, resized_q.size());
      fail_cnt++;
    end
    if (fail_cnt == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
